// ===== design/tnrn_pkg.sv =====
// tnrn_pkg: shared types, byte codes and constant tables of the telnet receive negotiator
// no dependencies; used by tnrn_parser and telnet_receive_negotiator
package tnrn_pkg;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_AYT  = 8'd246;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_NUL  = 8'h00;
    localparam logic [7:0] B_LF   = 8'h0A;
    localparam logic [7:0] B_CR   = 8'h0D;
    localparam logic [7:0] B_BS   = 8'h08;
    localparam logic [7:0] B_DEL  = 8'h7F;
    localparam logic [7:0] OPT_NAWS = 8'd31;

    localparam int SUB_LIMIT_DEF   = 255;
    localparam int NUM_OPTIONS_DEF = 4;

    localparam int TABLE_LEN = 4;
    localparam int OPT_IDX_W = 2;
    localparam int SUB_KEEP  = 5;
    localparam int AYT_LEN   = 15;
    localparam int DIM_W     = 15;

    localparam logic [DIM_W-1:0] COLS_RESET = 15'd80;
    localparam logic [DIM_W-1:0] ROWS_RESET = 15'd24;

    localparam logic [7:0] OPT_CODE [TABLE_LEN] = '{8'd1, 8'd3, 8'd3, 8'd31};
    localparam logic       OPT_REMOTE [TABLE_LEN] = '{1'b0, 1'b0, 1'b1, 1'b1};

    typedef enum logic [1:0] {
        OS_PENDING   = 2'd0,
        OS_REQUESTED = 2'd1,
        OS_AGREED    = 2'd2,
        OS_REJECTED  = 2'd3
    } opt_state_t;

    typedef enum logic [3:0] {
        PS_NORMAL = 4'd0,
        PS_CMD    = 4'd1,
        PS_WILL   = 4'd2,
        PS_WONT   = 4'd3,
        PS_DO     = 4'd4,
        PS_DONT   = 4'd5,
        PS_SUB    = 4'd6,
        PS_SUBEND = 4'd7,
        PS_RETURN = 4'd8
    } parse_state_t;

    typedef enum logic [2:0] {
        JOB_NONE  = 3'd0,
        JOB_CHAR  = 3'd1,
        JOB_AYT   = 3'd2,
        JOB_REPLY = 3'd3,
        JOB_START = 3'd4
    } job_kind_t;

    // burst of results that one item causes
    typedef struct packed {
        job_kind_t             kind;
        logic [7:0]            b1;
        logic [7:0]            b2;
        logic [TABLE_LEN-1:0]  mask;
    } job_t;

    localparam int AYT_IDX_W = 4;

    function automatic logic [7:0] ayt_byte(input logic [AYT_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h0A;
            4'd1:    b = 8'h0D;
            4'd2:    b = 8'h5B;
            4'd3:    b = 8'h76;
            4'd4:    b = 8'h64;
            4'd5:    b = 8'h72;
            4'd6:    b = 8'h20;
            4'd7:    b = 8'h3A;
            4'd8:    b = 8'h20;
            4'd9:    b = 8'h79;
            4'd10:   b = 8'h65;
            4'd11:   b = 8'h73;
            4'd12:   b = 8'h5D;
            4'd13:   b = 8'h0A;
            4'd14:   b = 8'h0D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/tnrn_cmd_if.sv =====
// tnrn_cmd_if: input channel of the telnet receive negotiator
// valid/ready handshake carrying action and received byte; no dependencies
interface tnrn_cmd_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// ===== design/tnrn_result_if.sv =====
// tnrn_result_if: result channel of the telnet receive negotiator
// valid/ready handshake carrying dest, byte, last flag and window size; no dependencies
interface tnrn_result_if;
    logic        valid;
    logic        ready;
    logic        dest;
    logic [7:0]  out_byte;
    logic        last;
    logic [14:0] cols;
    logic [14:0] rows;

    modport source (output valid, output dest, output out_byte, output last,
                    output cols, output rows, input ready);
    modport sink (input valid, input dest, input out_byte, input last,
                  input cols, input rows, output ready);
endinterface

// ===== design/tnrn_parser.sv =====
// tnrn_parser: telnet byte parser, option table, subnegotiation store and window size
// depends on tnrn_pkg; turns each accepted item into a result burst descriptor
module tnrn_parser #(
    parameter int SUB_LIMIT   = tnrn_pkg::SUB_LIMIT_DEF,
    parameter int NUM_OPTIONS = tnrn_pkg::NUM_OPTIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             action,
    input  logic [7:0]                       rx_byte,
    output tnrn_pkg::job_t                   job,
    output logic [tnrn_pkg::DIM_W-1:0]       cols,
    output logic [tnrn_pkg::DIM_W-1:0]       rows
);
    import tnrn_pkg::*;

    localparam int NUM_ENTRIES = (NUM_OPTIONS < TABLE_LEN) ? NUM_OPTIONS : TABLE_LEN;
    localparam int CNT_W       = $clog2(SUB_LIMIT + 1);

    parse_state_t      state_reg, state_next;
    opt_state_t        opt_reg  [NUM_ENTRIES];
    opt_state_t        opt_next [NUM_ENTRIES];
    logic [7:0]        sub_reg  [SUB_KEEP];
    logic [7:0]        sub_next [SUB_KEEP];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [DIM_W-1:0]  rows_reg, rows_next;

    always_comb
    begin
        logic       plain;
        logic       accum;
        logic       found;
        logic       remote;
        logic       enable;
        logic [7:0] refuse;
        logic [7:0] agree;
        logic [15:0] w;
        logic [15:0] h;

        state_next = state_reg;
        opt_next   = opt_reg;
        sub_next   = sub_reg;
        count_next = count_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        job.kind   = JOB_NONE;
        job.b1     = rx_byte;
        job.b2     = rx_byte;
        job.mask   = '0;
        plain      = 1'b0;
        accum      = 1'b0;
        found      = 1'b0;
        remote     = (state_reg == PS_WILL) || (state_reg == PS_WONT);
        enable     = (state_reg == PS_WILL) || (state_reg == PS_DO);
        refuse     = remote ? B_DONT : B_WONT;
        agree      = remote ? B_DO : B_WILL;
        w          = {sub_reg[1], sub_reg[2]};
        h          = {sub_reg[3], sub_reg[4]};

        if (accept)
        begin
            if (action)
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                begin
                    if (opt_reg[k] == OS_PENDING)
                    begin
                        opt_next[k] = OS_REQUESTED;
                        job.mask[k] = 1'b1;
                    end
                end
                if (job.mask != '0)
                begin
                    job.kind = JOB_START;
                end
            end
            else
            begin
                case (state_reg)
                    PS_NORMAL:
                    begin
                        plain = 1'b1;
                    end
                    PS_RETURN:
                    begin
                        state_next = PS_NORMAL;
                        plain = (rx_byte != B_NUL) && (rx_byte != B_LF);
                    end
                    PS_CMD:
                    begin
                        state_next = PS_NORMAL;
                        case (rx_byte)
                            B_IAC:   job.kind = JOB_CHAR;
                            B_SB:    state_next = PS_SUB;
                            B_AYT:   job.kind = JOB_AYT;
                            B_WILL:  state_next = PS_WILL;
                            B_WONT:  state_next = PS_WONT;
                            B_DO:    state_next = PS_DO;
                            B_DONT:  state_next = PS_DONT;
                            default: state_next = PS_NORMAL;
                        endcase
                    end
                    PS_WILL, PS_WONT, PS_DO, PS_DONT:
                    begin
                        state_next = PS_NORMAL;
                        for (int i = 0; i < NUM_ENTRIES; i++)
                        begin
                            if (OPT_CODE[i] == rx_byte && OPT_REMOTE[i] == remote)
                            begin
                                found = 1'b1;
                                if (enable)
                                begin
                                    if (opt_reg[i] != OS_AGREED)
                                    begin
                                        if (opt_reg[i] != OS_REQUESTED)
                                        begin
                                            job.kind = JOB_REPLY;
                                            job.b1   = agree;
                                        end
                                        opt_next[i] = OS_AGREED;
                                    end
                                end
                                else
                                begin
                                    if (opt_reg[i] != OS_REJECTED)
                                    begin
                                        if (opt_reg[i] != OS_REQUESTED)
                                        begin
                                            job.kind = JOB_REPLY;
                                            job.b1   = refuse;
                                        end
                                        opt_next[i] = OS_REJECTED;
                                    end
                                end
                            end
                        end
                        if (!found)
                        begin
                            job.kind = JOB_REPLY;
                            job.b1   = refuse;
                        end
                    end
                    PS_SUB:
                    begin
                        if (rx_byte == B_IAC)
                        begin
                            state_next = PS_SUBEND;
                        end
                        else
                        begin
                            accum = 1'b1;
                        end
                    end
                    PS_SUBEND:
                    begin
                        state_next = PS_NORMAL;
                        if (rx_byte == B_IAC)
                        begin
                            accum = 1'b1;
                            state_next = PS_SUB;
                        end
                        else if (rx_byte == B_SE)
                        begin
                            count_next = '0;
                            if (count_reg == CNT_W'(SUB_KEEP) && sub_reg[0] == OPT_NAWS)
                            begin
                                if (!w[15])
                                begin
                                    cols_next = w[DIM_W-1:0];
                                end
                                if (!h[15])
                                begin
                                    rows_next = h[DIM_W-1:0];
                                end
                            end
                        end
                        else
                        begin
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        state_next = PS_NORMAL;
                    end
                endcase

                if (plain)
                begin
                    if (rx_byte == B_IAC)
                    begin
                        state_next = PS_CMD;
                    end
                    else if (rx_byte == B_BS)
                    begin
                        job.kind = JOB_CHAR;
                        job.b1   = B_DEL;
                    end
                    else if (rx_byte == B_CR)
                    begin
                        job.kind   = JOB_CHAR;
                        state_next = PS_RETURN;
                    end
                    else
                    begin
                        job.kind = JOB_CHAR;
                    end
                end

                if (accum && count_reg < CNT_W'(SUB_LIMIT))
                begin
                    if (count_reg < CNT_W'(SUB_KEEP))
                    begin
                        sub_next[count_reg[2:0]] = rx_byte;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_NORMAL;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                opt_reg[k] <= OS_PENDING;
            end
            count_reg <= '0;
            cols_reg  <= COLS_RESET;
            rows_reg  <= ROWS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            opt_reg   <= opt_next;
            count_reg <= count_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
        end
    end

    // subnegotiation bytes, undefined until written
    always_ff @(posedge clk)
    begin
        sub_reg <= sub_next;
    end

    assign cols = cols_reg;
    assign rows = rows_reg;

endmodule

// ===== design/telnet_receive_negotiator.sv =====
// telnet_receive_negotiator: top level, parser plus result burst sequencer
// depends on tnrn_pkg, tnrn_cmd_if, tnrn_result_if and tnrn_parser
//
//  channel  | modport | payload                               | per item
//  ---------+---------+---------------------------------------+------------------
//  cmd      | sink    | action, rx_byte                       | one item in
//  result   | source  | dest, out_byte, last, cols, rows      | 0 to 15 items out
//
// an item is parsed and the protocol state updated in the cycle it is accepted
// its results come from the burst register, one per cycle while result.ready is high, starting the next cycle
// a new item is taken while the last result of the previous one is taken
// items with one or no result run at one per cycle while result.ready is high
// reset puts the parser in normal state, all options pending, window 80 by 24
module telnet_receive_negotiator #(
    parameter int SUB_LIMIT   = tnrn_pkg::SUB_LIMIT_DEF,
    parameter int NUM_OPTIONS = tnrn_pkg::NUM_OPTIONS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    tnrn_cmd_if.sink    cmd,
    tnrn_result_if.source result
);
    import tnrn_pkg::*;

    job_kind_t               kind_reg, kind_next;
    logic [AYT_IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]              b1_reg, b1_next;
    logic [7:0]              b2_reg, b2_next;
    logic [TABLE_LEN-1:0]    mask_reg, mask_next;

    job_t                    job;
    logic                    accept;
    logic                    take;
    logic                    last;
    logic                    dest;
    logic [7:0]              out_byte;
    logic [OPT_IDX_W-1:0]    entry;
    logic [DIM_W-1:0]        cols;
    logic [DIM_W-1:0]        rows;

    tnrn_parser #(
        .SUB_LIMIT   (SUB_LIMIT),
        .NUM_OPTIONS (NUM_OPTIONS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (cmd.action),
        .rx_byte (cmd.rx_byte),
        .job     (job),
        .cols    (cols),
        .rows    (rows)
    );

    // lowest pending entry of a start burst
    always_comb
    begin
        entry = '0;
        for (int i = TABLE_LEN - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                entry = OPT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        dest     = 1'b1;
        out_byte = B_IAC;
        last     = 1'b0;
        case (kind_reg)
            JOB_CHAR:
            begin
                dest     = 1'b0;
                out_byte = b1_reg;
                last     = 1'b1;
            end
            JOB_AYT:
            begin
                dest     = 1'b0;
                out_byte = ayt_byte(idx_reg);
                last     = (idx_reg == AYT_IDX_W'(AYT_LEN - 1));
            end
            JOB_REPLY:
            begin
                if (idx_reg == AYT_IDX_W'(1))
                begin
                    out_byte = b1_reg;
                end
                else if (idx_reg == AYT_IDX_W'(2))
                begin
                    out_byte = b2_reg;
                end
                last = (idx_reg == AYT_IDX_W'(2));
            end
            JOB_START:
            begin
                if (idx_reg == AYT_IDX_W'(1))
                begin
                    out_byte = OPT_REMOTE[entry] ? B_DO : B_WILL;
                end
                else if (idx_reg == AYT_IDX_W'(2))
                begin
                    out_byte = OPT_CODE[entry];
                end
                last = (idx_reg == AYT_IDX_W'(2))
                    && ((mask_reg & (mask_reg - TABLE_LEN'(1))) == '0);
            end
            default:
            begin
                last = 1'b0;
            end
        endcase
    end

    assign take   = result.valid && result.ready;
    assign accept = cmd.valid && cmd.ready;

    assign cmd.ready       = (kind_reg == JOB_NONE) || (result.ready && last);
    assign result.valid    = (kind_reg != JOB_NONE);
    assign result.dest     = dest;
    assign result.out_byte = out_byte;
    assign result.last     = last;
    assign result.cols     = cols;
    assign result.rows     = rows;

    always_comb
    begin
        kind_next = kind_reg;
        idx_next  = idx_reg;
        b1_next   = b1_reg;
        b2_next   = b2_reg;
        mask_next = mask_reg;
        if (accept)
        begin
            kind_next = job.kind;
            idx_next  = '0;
            b1_next   = job.b1;
            b2_next   = job.b2;
            mask_next = job.mask;
        end
        else if (take)
        begin
            if (last)
            begin
                kind_next = JOB_NONE;
            end
            else if (kind_reg == JOB_START && idx_reg == AYT_IDX_W'(2))
            begin
                idx_next = '0;
                mask_next[entry] = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + AYT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= JOB_NONE;
        end
        else
        begin
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        mask_reg <= mask_next;
    end

endmodule
